FILE: rtl/lmgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmgs_pkg
// shared codes, constants and control structs for the led matrix grayscale scan
// ----------------------------------------------------------------------------
package lmgs_pkg;

    localparam int OP_W       = 3;
    localparam int XY_W       = 4;
    localparam int LEVEL_W    = 2;
    localparam int ROW_BITS_W = 16;
    localparam int COL_OUT_W  = 4;
    localparam int SKIP_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_INVERT = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAYSCALE   = 2'd1;

    // phases counted back from the end of the shade cycle
    localparam logic [7:0] SHADE_BOTH_TAIL = 8'd6;
    localparam logic [7:0] SHADE_HIGH_TAIL = 8'd5;

    // which planes light a row in the current phase
    typedef struct packed {
        logic and_mode;   // lit only at full level
        logic high_mode;  // lit when high plane set
    } shade_ctl_t;

    typedef struct packed {
        logic set_en;
        logic invert_en;
        logic clear_en;
    } store_cmd_t;

    typedef struct packed {
        logic frame_start;
        logic drive_enable;
        logic drive_enable_next;
    } scan_status_t;

endpackage

`default_nettype wire

FILE: rtl/lmgs_frame_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmgs_frame_store
// two bit planes of pixel flops with set, invert, clear, pixel read and column read
// ----------------------------------------------------------------------------
module lmgs_frame_store
    import lmgs_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int COLS = 16,
    parameter int CW   = $clog2(COLS)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire store_cmd_t            cmd,
    input  wire logic [XY_W-1:0]       x_pos,
    input  wire logic [XY_W-1:0]       y_pos,
    input  wire logic [LEVEL_W-1:0]    level,
    input  wire logic [CW-1:0]         scan_col,
    input  wire shade_ctl_t            shade,
    output logic [ROW_BITS_W-1:0]      row_bits,
    output logic [LEVEL_W-1:0]         pixel_level
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [COLS-1:0] lo_reg [ROWS];
    logic [COLS-1:0] hi_reg [ROWS];

    logic [5:0]      x_wide;
    logic [5:0]      y_wide;
    logic            in_range;
    logic [CW-1:0]   x_idx;
    logic [RW-1:0]   y_idx;

    assign x_wide   = 6'(x_pos);
    assign y_wide   = 6'(y_pos);
    assign in_range = (x_wide < 6'(COLS)) && (y_wide < 6'(ROWS));
    assign x_idx    = x_wide[CW-1:0];
    assign y_idx    = y_wide[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                lo_reg[r] <= '0;
                hi_reg[r] <= '0;
            end
        end
        else if (cmd.clear_en)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                lo_reg[r] <= '0;
                hi_reg[r] <= '0;
            end
        end
        else if (cmd.invert_en)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                lo_reg[r] <= ~lo_reg[r];
                hi_reg[r] <= ~hi_reg[r];
            end
        end
        else if (cmd.set_en && in_range)
        begin
            lo_reg[y_idx][x_idx] <= level[0];
            hi_reg[y_idx][x_idx] <= level[1];
        end
    end

    always_comb
    begin
        pixel_level = '0;
        if (in_range)
        begin
            pixel_level = {hi_reg[y_idx][x_idx], lo_reg[y_idx][x_idx]};
        end
    end

    // only the first 16 rows reach the row driver
    for (genvar r = 0; r < ROW_BITS_W; r++)
    begin : g_row
        if (r < ROWS)
        begin : g_used
            logic lo_bit;
            logic hi_bit;
            assign lo_bit = lo_reg[r][scan_col];
            assign hi_bit = hi_reg[r][scan_col];
            assign row_bits[r] = shade.and_mode  ? (lo_bit & hi_bit) :
                                 shade.high_mode ? hi_bit : (lo_bit | hi_bit);
        end
        else
        begin : g_unused
            assign row_bits[r] = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lmgs_scan_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmgs_scan_ctrl
// column counter, shade phase, frame skipping and display enable
// ----------------------------------------------------------------------------
module lmgs_scan_ctrl
    import lmgs_pkg::*;
#(
    parameter int COLS         = 16,
    parameter int SHADE_PHASES = 21,
    parameter int CNTW         = $clog2(COLS + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire logic [SKIP_W-1:0] drop_frames,
    input  wire logic              grayscale_enable,
    output logic [CNTW-1:0]        scan_col,
    output scan_status_t           status,
    output shade_ctl_t             shade
);

    localparam int PW = $clog2(SHADE_PHASES);

    logic [CNTW-1:0]   col_reg;
    logic [CNTW-1:0]   col_next;
    logic [PW-1:0]     phase_reg;
    logic [PW-1:0]     phase_next;
    logic [SKIP_W-1:0] skip_reg;
    logic [SKIP_W-1:0] skip_inc;
    logic [SKIP_W-1:0] skip_next;
    logic              drive_reg;
    logic              keep_frame;
    logic              frame_start;

    assign frame_start = (col_reg >= CNTW'(COLS));
    assign scan_col    = frame_start ? '0 : col_reg;
    assign col_next    = scan_col + 1'b1;

    assign skip_inc    = skip_reg + 1'b1;
    assign keep_frame  = (skip_inc >= drop_frames);
    assign skip_next   = keep_frame ? '0 : skip_inc;

    always_comb
    begin
        phase_next = phase_reg;
        if (frame_start)
        begin
            phase_next = (phase_reg == PW'(SHADE_PHASES - 1)) ? '0 : phase_reg + 1'b1;
        end
    end

    // row mode follows the phase of the frame that this step belongs to
    assign shade.and_mode  = grayscale_enable &&
                             ((8'(phase_next) + SHADE_BOTH_TAIL) < 8'(SHADE_PHASES));
    assign shade.high_mode = grayscale_enable &&
                             ((8'(phase_next) + SHADE_HIGH_TAIL) > 8'(SHADE_PHASES));

    assign status.frame_start       = frame_start;
    assign status.drive_enable      = drive_reg;
    assign status.drive_enable_next = frame_start ? keep_frame : drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            phase_reg <= '0;
            skip_reg  <= '0;
            drive_reg <= 1'b1;
        end
        else if (step_en)
        begin
            col_reg   <= col_next;
            phase_reg <= phase_next;
            if (frame_start)
            begin
                skip_reg  <= skip_next;
                drive_reg <= keep_frame;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/led_matrix_grayscale_scan_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_grayscale_scan_top
// multiplexed led matrix scan with a 2-bit grayscale frame store
// ----------------------------------------------------------------------------
// One transaction per clock is accepted while the output is not stalled, and each
// one returns exactly one result: an input register holds the command, the frame
// store and scan counters act on it in that cycle, and a result register holds
// the outcome until the sink takes it. A stalled result holds the command in the
// input register and stalls the input. The frame store is flops, so a scan step
// reads a whole column of row bits at once and invert or clear touch every pixel
// together. A scan step past the last column starts a new frame, advances the
// shade phase and updates frame skipping; set and read ignore positions outside
// the matrix. Configuration writes take effect at once and are meant for an
// idle block.
module led_matrix_grayscale_scan_top
    import lmgs_pkg::*;
#(
    parameter int ROWS         = 16,
    parameter int COLS         = 16,
    parameter int SHADE_PHASES = 21
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [OP_W-1:0]       op,
    input  wire logic [XY_W-1:0]       x_pos,
    input  wire logic [XY_W-1:0]       y_pos,
    input  wire logic [LEVEL_W-1:0]    level,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [COL_OUT_W-1:0]       column_index,
    output logic                       column_select_bit,
    output logic [ROW_BITS_W-1:0]      row_bits,
    output logic                       display_enable,
    output logic [LEVEL_W-1:0]         pixel_level,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW   = $clog2(COLS);
    localparam int CNTW = $clog2(COLS + 1);

    // configuration
    logic [SKIP_W-1:0] drop_frames_reg;
    logic              grayscale_enable_reg;

    // input stage
    logic               s1_valid_reg;
    logic [OP_W-1:0]    s1_op_reg;
    logic [XY_W-1:0]    s1_x_reg;
    logic [XY_W-1:0]    s1_y_reg;
    logic [LEVEL_W-1:0] s1_level_reg;

    // result stage
    logic                  out_valid_reg;
    logic [COL_OUT_W-1:0]  col_out_reg;
    logic [COL_OUT_W-1:0]  col_out_next;
    logic                  sel_reg;
    logic                  sel_next;
    logic [ROW_BITS_W-1:0] rows_reg;
    logic [ROW_BITS_W-1:0] rows_next;
    logic                  enable_reg;
    logic                  enable_next;
    logic [LEVEL_W-1:0]    pix_reg;
    logic [LEVEL_W-1:0]    pix_next;

    logic                  out_ready;
    logic                  in_accept;
    logic                  fire;
    logic                  step_en;
    store_cmd_t            cmd;
    scan_status_t          status;
    shade_ctl_t            shade;
    logic [CNTW-1:0]       scan_col;
    logic [7:0]            scan_col_wide;
    logic [ROW_BITS_W-1:0] store_rows;
    logic [LEVEL_W-1:0]    store_pix;

    assign out_ready = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_frames_reg      <= '0;
            grayscale_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DROP_FRAMES: drop_frames_reg      <= cfg_data;
                CFG_GRAYSCALE:   grayscale_enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg    <= op;
            s1_x_reg     <= x_pos;
            s1_y_reg     <= y_pos;
            s1_level_reg <= level;
        end
    end

    assign step_en       = fire && (s1_op_reg == OP_SCAN);
    assign cmd.set_en    = fire && (s1_op_reg == OP_SET);
    assign cmd.invert_en = fire && (s1_op_reg == OP_INVERT);
    assign cmd.clear_en  = fire && (s1_op_reg == OP_CLEAR);

    lmgs_scan_ctrl #(
        .COLS         (COLS),
        .SHADE_PHASES (SHADE_PHASES),
        .CNTW         (CNTW)
    ) u_scan_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (step_en),
        .drop_frames      (drop_frames_reg),
        .grayscale_enable (grayscale_enable_reg),
        .scan_col         (scan_col),
        .status           (status),
        .shade            (shade)
    );

    lmgs_frame_store #(
        .ROWS (ROWS),
        .COLS (COLS),
        .CW   (CW)
    ) u_frame_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .x_pos       (s1_x_reg),
        .y_pos       (s1_y_reg),
        .level       (s1_level_reg),
        .scan_col    (scan_col[CW-1:0]),
        .shade       (shade),
        .row_bits    (store_rows),
        .pixel_level (store_pix)
    );

    assign scan_col_wide = 8'(scan_col);

    always_comb
    begin
        col_out_next = '0;
        sel_next     = 1'b0;
        rows_next    = '0;
        enable_next  = status.drive_enable;
        pix_next     = '0;
        case (s1_op_reg)
            OP_SCAN:
            begin
                col_out_next = scan_col_wide[COL_OUT_W-1:0];
                sel_next     = !status.frame_start;
                rows_next    = store_rows;
                enable_next  = status.drive_enable_next;
            end
            OP_READ:
            begin
                pix_next = store_pix;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            col_out_reg <= col_out_next;
            sel_reg     <= sel_next;
            rows_reg    <= rows_next;
            enable_reg  <= enable_next;
            pix_reg     <= pix_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign column_index      = col_out_reg;
    assign column_select_bit = sel_reg;
    assign row_bits          = rows_reg;
    assign display_enable    = enable_reg;
    assign pixel_level       = pix_reg;

    // a frame start always drives the first column
    a_frame_start_col0: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !column_select_bit) |-> (column_index == '0))
        else $error("column select low on a column other than zero");

    // a read result never carries scan data
    a_read_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (pixel_level != '0)) |-> ((row_bits == '0) && !column_select_bit))
        else $error("pixel read result carries row bits");

    // a held command moves on as soon as the result register is empty
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input stage did not advance into an empty result register");

endmodule

`default_nettype wire
